/* rtl/core/srfc_pkg.sv */
`default_nettype none

package srfc_pkg;

  // Default header hunt limit; the counter holds 0..15
  localparam int unsigned HUNT_LIMIT_DEF = 10;
  localparam int unsigned HUNT_W         = 4;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] ANY_ID   = 8'hFE;
  // Length byte carries data bytes plus status and checksum
  localparam logic [8:0] LEN_EXTRA = 9'd2;

  // Request codes
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_BYTE    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_NO_REPLY = 3'd1;
  localparam logic [2:0] ERR_CHECKSUM = 3'd2;
  localparam logic [2:0] ERR_ID       = 3'd3;
  localparam logic [2:0] ERR_LEN      = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HUNT = 4'b0010,
    PH_HEAD = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] expected_id;
    logic [7:0] data_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [7:0]  servo_status;
    logic [15:0] read_value;
  } out_item_t;

  typedef struct packed {
    phase_t              phase;
    logic                last_was_ff;
    logic [HUNT_W-1:0]   hunt_count;
    logic [7:0]          byte_index;
    logic [7:0]          running_sum;
    logic [7:0]          want_id;
    logic [7:0]          want_len;
    logic [7:0]          got_id;
    logic [7:0]          got_len;
    logic [7:0]          got_status;
    logic [15:0]         value_bytes;
  } frame_state_t;

endpackage

`default_nettype wire

/* rtl/core/srfc_stream_if.sv */
`default_nettype none

interface srfc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/srfc_step.sv */
`default_nettype none

// Next-state and result logic for one accepted item
module srfc_step #(
  parameter int unsigned HUNT_LIMIT = srfc_pkg::HUNT_LIMIT_DEF
) (
  input  var srfc_pkg::frame_state_t st,
  input  var srfc_pkg::in_item_t     item,
  output srfc_pkg::frame_state_t     st_nxt,
  output logic                       res_valid,
  output srfc_pkg::out_item_t        res
);

  localparam logic [srfc_pkg::HUNT_W-1:0] HUNT_MAX = srfc_pkg::HUNT_W'(HUNT_LIMIT);

  logic       is_ff;
  logic [7:0] sum_add;
  logic       id_bad;
  logic       len_bad;
  logic       sum_bad;

  assign is_ff   = (item.rx_byte == srfc_pkg::HDR_BYTE);
  assign sum_add = st.running_sum + item.rx_byte;
  assign id_bad  = (st.got_id != st.want_id) && (st.want_id != srfc_pkg::ANY_ID);
  assign len_bad = ({1'b0, st.got_len} != ({1'b0, st.want_len} + srfc_pkg::LEN_EXTRA));
  assign sum_bad = (~st.running_sum != item.rx_byte);

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '{error_code: srfc_pkg::ERR_NO_REPLY, servo_status: 8'd0, read_value: 16'd0};
    unique case (item.req_type)
      srfc_pkg::REQ_START: begin
        // arm a fresh frame, dropping any in progress
        st_nxt             = '0;
        st_nxt.phase       = srfc_pkg::PH_HUNT;
        st_nxt.want_id     = item.expected_id;
        st_nxt.want_len    = item.data_len;
      end
      srfc_pkg::REQ_TIMEOUT: begin
        st_nxt.phase = srfc_pkg::PH_IDLE;
        res_valid    = 1'b1;
      end
      srfc_pkg::REQ_BYTE: begin
        unique case (st.phase)
          srfc_pkg::PH_HUNT: begin
            if (is_ff && st.last_was_ff) begin
              st_nxt.phase       = srfc_pkg::PH_HEAD;
              st_nxt.byte_index  = 8'd0;
              st_nxt.running_sum = 8'd0;
            end else begin
              st_nxt.last_was_ff = is_ff;
              if (st.hunt_count >= HUNT_MAX) begin
                st_nxt.phase = srfc_pkg::PH_IDLE;
                res_valid    = 1'b1;
              end else begin
                st_nxt.hunt_count = st.hunt_count + 1'b1;
              end
            end
          end
          srfc_pkg::PH_HEAD: begin
            priority if (st.byte_index == 8'd0) begin
              st_nxt.got_id = item.rx_byte;
            end else if (st.byte_index == 8'd1) begin
              st_nxt.got_len = item.rx_byte;
            end else begin
              st_nxt.got_status = item.rx_byte;
            end
            st_nxt.running_sum = sum_add;
            if (st.byte_index >= 8'd2) begin
              st_nxt.phase      = srfc_pkg::PH_DATA;
              st_nxt.byte_index = 8'd0;
            end else begin
              st_nxt.byte_index = st.byte_index + 8'd1;
            end
          end
          srfc_pkg::PH_DATA: begin
            if (st.byte_index < st.want_len) begin
              if (st.byte_index == 8'd0) begin
                st_nxt.value_bytes[7:0] = item.rx_byte;
              end else if (st.byte_index == 8'd1) begin
                st_nxt.value_bytes[15:8] = item.rx_byte;
              end
              st_nxt.running_sum = sum_add;
              st_nxt.byte_index  = st.byte_index + 8'd1;
            end else begin
              // checksum byte: report in order id, length, checksum
              st_nxt.phase = srfc_pkg::PH_IDLE;
              res_valid    = 1'b1;
              priority if (id_bad) begin
                res.error_code = srfc_pkg::ERR_ID;
              end else if (len_bad) begin
                res.error_code = srfc_pkg::ERR_LEN;
              end else if (sum_bad) begin
                res.error_code = srfc_pkg::ERR_CHECKSUM;
              end else begin
                res.error_code   = srfc_pkg::ERR_OK;
                res.servo_status = st.got_status;
                if (st.want_len == 8'd1) begin
                  res.read_value = {8'd0, st.value_bytes[7:0]};
                end else if (st.want_len == 8'd2) begin
                  res.read_value = st.value_bytes;
                end
              end
            end
          end
          default: begin
            // idle: drop the byte
          end
        endcase
      end
      default: begin
        // unused request code: hold state
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/servo_reply_frame_checker_core.sv */
`default_nettype none

// Channel   Dir  Payload                                          Handshake
// in_ch     in   req_type, rx_byte, expected_id, data_len         valid/ready
// out_ch    out  error_code, servo_status, read_value             valid/ready
//
// One item per cycle while in_ch.ready is high: the frame state updates in the cycle an item is taken.
// A result appears in the output register the cycle after its item.
// in_ch.ready is low only while a result waits and out_ch.ready is low.
// Reset (rst_n low, synchronous) returns the checker to idle with no result.
module servo_reply_frame_checker_core #(
  parameter int unsigned HUNT_LIMIT = srfc_pkg::HUNT_LIMIT_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  srfc_stream_if.sink          in_ch,
  srfc_stream_if.source        out_ch
);

  // Idle with every counter and captured byte cleared
  localparam srfc_pkg::frame_state_t ST_RESET = '{
    phase:       srfc_pkg::PH_IDLE,
    last_was_ff: 1'b0,
    hunt_count:  '0,
    byte_index:  8'd0,
    running_sum: 8'd0,
    want_id:     8'd0,
    want_len:    8'd0,
    got_id:      8'd0,
    got_len:     8'd0,
    got_status:  8'd0,
    value_bytes: 16'd0
  };

  srfc_pkg::frame_state_t st_r;
  srfc_pkg::frame_state_t st_nxt;
  srfc_pkg::in_item_t     item;
  srfc_pkg::out_item_t    res;
  srfc_pkg::out_item_t    out_r;
  logic                   res_valid;
  logic                   out_valid_r;
  logic                   in_take;

  assign item = in_ch.payload;

  // Accept whenever the output register is empty or draining this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  srfc_step #(
    .HUNT_LIMIT(HUNT_LIMIT)
  ) u_step (
    .st       (st_r),
    .item     (item),
    .st_nxt   (st_nxt),
    .res_valid(res_valid),
    .res      (res)
  );

  // Frame state: advance only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // Output register: load a new result, drop a taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // A failed frame never carries status or value
  a_err_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.error_code != srfc_pkg::ERR_OK) |->
      (out_r.servo_status == 8'd0) && (out_r.read_value == 16'd0))
    else $error("error result carries data");

  // A timeout always yields no reply and leaves the checker idle
  a_timeout : assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (item.req_type == srfc_pkg::REQ_TIMEOUT) |=>
      out_valid_r && (out_r.error_code == srfc_pkg::ERR_NO_REPLY) &&
      (st_r.phase == srfc_pkg::PH_IDLE))
    else $error("timeout mishandled");

  // A start arms the hunt with a cleared counter
  a_start : assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (item.req_type == srfc_pkg::REQ_START) |=>
      (st_r.phase == srfc_pkg::PH_HUNT) && (st_r.hunt_count == '0) && !st_r.last_was_ff)
    else $error("start did not arm hunt");

  // The hunt counter never passes the limit
  a_hunt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == srfc_pkg::PH_HUNT) |->
      (st_r.hunt_count <= srfc_pkg::HUNT_W'(HUNT_LIMIT)))
    else $error("hunt counter overran");

  // No new item is taken over a stalled result
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_take)
    else $error("item taken over stalled result");

endmodule

`default_nettype wire
